### src/bmhq_pkg.sv
// shared types and constants for the binary min-heap priority queue
`default_nettype none

package bmhq_pkg;

    localparam int HANDLE_W = 16;
    localparam int PRIO_W   = 32;
    localparam int ENTRY_W  = HANDLE_W + PRIO_W;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_FAIL_FULL,
        OP_FAIL_EMPTY,
        OP_INS_START,
        OP_UP_SWAP,
        OP_UP_PLACE,
        OP_REM_START,
        OP_DN_SWAP,
        OP_DN_PLACE,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t op;
    } bmhq_ctl_t;

    typedef struct packed {
        logic is_remove;
        logic empty;
        logic full;
        logic up_swap;
        logic dn_swap;
    } bmhq_flags_t;

endpackage

`default_nettype wire

### src/binary_min_heap_queue_top.sv
// sequence: load, decide, then swap steps (up on insert, down on remove) for each
// level moved, then place and publish; a rejected operation skips to publish
// throughput: one operation at a time, next input taken the cycle after the result
// is registered; one heap level per cycle, set by the registered memory read port
// reset: rst_n clears the entry count, state machine and output valid at once;
// heap memory is not cleared and needs no clearing pass
`default_nettype none

module binary_min_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                command,
    input  wire logic [HANDLE_W-1:0] item_handle,
    input  wire logic [PRIO_W-1:0]   priority_req,
    // result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_W-1:0]      top_handle,
    output logic [PRIO_W-1:0]        top_priority,
    output logic [COUNT_W-1:0]       count
);

    // command from the state machine, status back from the datapath
    bmhq_ctl_t   ctl;
    bmhq_flags_t flags;

    // controller: accepts one transfer, walks the sift, then publishes the
    // result into the output register; a pending result under stall only
    // blocks the publish step, not the sift of the next item
    bmhq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .ctl       (ctl)
    );

    // datapath: heap memory with two registered read ports, hole index and
    // moving entry registers; each sift level is one compare and one write,
    // with the next level's read issued in the same cycle
    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .item_handle  (item_handle),
        .priority_req (priority_req),
        .ctl          (ctl),
        .flags        (flags),
        .status       (status),
        .top_handle   (top_handle),
        .top_priority (top_priority),
        .count        (count)
    );

endmodule

`default_nettype wire

### src/bmhq_datapath.sv
// heap memory, sift datapath and result registers
`default_nettype none

module bmhq_datapath
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                command,
    input  wire logic [HANDLE_W-1:0] item_handle,
    input  wire logic [PRIO_W-1:0]   priority_req,
    input  wire bmhq_ctl_t           ctl,
    output bmhq_flags_t              flags,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_W-1:0]      top_handle,
    output logic [PRIO_W-1:0]        top_priority,
    output logic [COUNT_W-1:0]       count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;

    logic [ENTRY_W-1:0] mem [CAPACITY];

    logic [ENTRY_W-1:0]  rd_a_reg;
    logic [ENTRY_W-1:0]  rd_b_reg;
    logic [ENTRY_W-1:0]  item_reg;
    logic [ENTRY_W-1:0]  item_next;
    logic [IW-1:0]       hole_reg;
    logic [IW-1:0]       hole_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                cmd_reg;
    logic                cmd_next;
    status_t             res_status_reg;
    status_t             res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic [HANDLE_W-1:0] res_handle_next;
    logic [PRIO_W-1:0]   res_prio_reg;
    logic [PRIO_W-1:0]   res_prio_next;
    logic [STATUS_W-1:0] status_reg;
    logic [HANDLE_W-1:0] top_handle_reg;
    logic [PRIO_W-1:0]   top_prio_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [IW-1:0]       addr_a;
    logic [IW-1:0]       addr_b;
    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_data;

    logic [XW-1:0]       hole_x;
    logic [XW-1:0]       left_x;
    logic [XW-1:0]       right_x;
    logic [XW-1:0]       n_x;
    logic                has_left;
    logic                has_right;
    logic                right_pick;
    logic [XW-1:0]       pick_x;
    logic [XW-1:0]       pick_left_x;
    logic [ENTRY_W-1:0]  pick_data;
    logic signed [PRIO_W-1:0] prio_a;
    logic signed [PRIO_W-1:0] prio_b;
    logic signed [PRIO_W-1:0] prio_item;
    logic signed [PRIO_W-1:0] prio_pick;

    logic [IW-1:0]       hole_dec;
    logic [IW-1:0]       parent_i;
    logic [IW-1:0]       parent_dec;
    logic [IW-1:0]       gparent_i;
    logic [IW-1:0]       cnt_i;
    logic [IW-1:0]       cnt_dec;
    logic [IW-1:0]       ins_parent_i;
    logic [IW-1:0]       last_i;

    // child index math in a width that holds 2*capacity
    assign hole_x      = XW'(hole_reg);
    assign left_x      = (hole_x << 1) + XW'(1);
    assign right_x     = left_x + XW'(1);
    assign n_x         = XW'(cnt_reg);
    assign has_left    = left_x < n_x;
    assign has_right   = right_x < n_x;

    assign prio_a      = $signed(rd_a_reg[PRIO_W-1:0]);
    assign prio_b      = $signed(rd_b_reg[PRIO_W-1:0]);
    assign prio_item   = $signed(item_reg[PRIO_W-1:0]);

    // ties go to the right child
    assign right_pick  = has_right && !(prio_a < prio_b);
    assign pick_x      = right_pick ? right_x : left_x;
    assign pick_data   = right_pick ? rd_b_reg : rd_a_reg;
    assign prio_pick   = $signed(pick_data[PRIO_W-1:0]);
    assign pick_left_x = (pick_x << 1) + XW'(1);

    // parent and grandparent of the hole
    assign hole_dec     = hole_reg - IW'(1);
    assign parent_i     = hole_dec >> 1;
    assign parent_dec   = parent_i - IW'(1);
    assign gparent_i    = parent_dec >> 1;
    assign cnt_i        = IW'(cnt_reg);
    assign cnt_dec      = cnt_i - IW'(1);
    assign ins_parent_i = cnt_dec >> 1;
    assign last_i       = IW'(cnt_reg - CW'(1));

    assign flags.is_remove = (cmd_reg == CMD_REMOVE);
    assign flags.empty     = (cnt_reg == '0);
    assign flags.full      = (cnt_reg >= CW'(CAPACITY));
    assign flags.up_swap   = (hole_reg != '0) && (prio_a > prio_item);
    assign flags.dn_swap   = has_left && (prio_pick < prio_item);

    always_comb
    begin
        item_next       = item_reg;
        hole_next       = hole_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_prio_next   = res_prio_reg;
        addr_a          = '0;
        addr_b          = '0;
        wr_en           = 1'b0;
        wr_data         = item_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_next  = command;
                item_next = {item_handle, priority_req};
                addr_a    = '0;
                addr_b    = last_i;
            end
            OP_FAIL_FULL:
            begin
                res_status_next = ST_FULL;
                res_handle_next = '0;
                res_prio_next   = '0;
            end
            OP_FAIL_EMPTY:
            begin
                res_status_next = ST_EMPTY;
                res_handle_next = '0;
                res_prio_next   = '0;
            end
            OP_INS_START:
            begin
                res_status_next = ST_OK;
                res_handle_next = '0;
                res_prio_next   = '0;
                hole_next       = cnt_i;
                cnt_next        = cnt_reg + CW'(1);
                addr_a          = ins_parent_i;
            end
            OP_UP_SWAP:
            begin
                // parent moves down into the hole
                wr_en     = 1'b1;
                wr_data   = rd_a_reg;
                hole_next = parent_i;
                addr_a    = gparent_i;
            end
            OP_UP_PLACE:
            begin
                wr_en   = 1'b1;
                wr_data = item_reg;
            end
            OP_REM_START:
            begin
                res_status_next = ST_OK;
                res_handle_next = rd_a_reg[ENTRY_W-1:PRIO_W];
                res_prio_next   = rd_a_reg[PRIO_W-1:0];
                item_next       = rd_b_reg;
                cnt_next        = cnt_reg - CW'(1);
                hole_next       = '0;
                addr_a          = IW'(XW'(1));
                addr_b          = IW'(XW'(2));
            end
            OP_DN_SWAP:
            begin
                // smaller child moves up into the hole
                wr_en     = 1'b1;
                wr_data   = pick_data;
                hole_next = IW'(pick_x);
                addr_a    = IW'(pick_left_x);
                addr_b    = IW'(pick_left_x + XW'(1));
            end
            OP_DN_PLACE:
            begin
                wr_en   = 1'b1;
                wr_data = item_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[hole_reg] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        hole_reg       <= hole_next;
        cmd_reg        <= cmd_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_prio_reg   <= res_prio_next;
        if (ctl.op == OP_PUBLISH)
        begin
            status_reg     <= res_status_reg;
            top_handle_reg <= res_handle_reg;
            top_prio_reg   <= res_prio_reg;
            count_reg      <= COUNT_W'(cnt_reg);
        end
    end

    assign status       = status_reg;
    assign top_handle   = top_handle_reg;
    assign top_priority = top_prio_reg;
    assign count        = count_reg;

endmodule

`default_nettype wire

### src/bmhq_ctrl.sv
// sequencing state machine for the heap queue
`default_nettype none

module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire bmhq_flags_t flags,
    output bmhq_ctl_t        ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_UP,
        S_DOWN,
        S_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl.op         = OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (flags.is_remove)
                begin
                    if (flags.empty)
                    begin
                        ctl.op     = OP_FAIL_EMPTY;
                        state_next = S_PUBLISH;
                    end
                    else
                    begin
                        ctl.op     = OP_REM_START;
                        state_next = S_DOWN;
                    end
                end
                else
                begin
                    if (flags.full)
                    begin
                        ctl.op     = OP_FAIL_FULL;
                        state_next = S_PUBLISH;
                    end
                    else
                    begin
                        ctl.op     = OP_INS_START;
                        state_next = S_UP;
                    end
                end
            end
            S_UP:
            begin
                if (flags.up_swap)
                begin
                    ctl.op = OP_UP_SWAP;
                end
                else
                begin
                    ctl.op     = OP_UP_PLACE;
                    state_next = S_PUBLISH;
                end
            end
            S_DOWN:
            begin
                if (flags.dn_swap)
                begin
                    ctl.op = OP_DN_SWAP;
                end
                else
                begin
                    ctl.op     = OP_DN_PLACE;
                    state_next = S_PUBLISH;
                end
            end
            S_PUBLISH:
            begin
                // output slot is free or empties at this edge
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### src/bmhq_checker.sv
// port-level checks for the heap queue and their binding to the top level
`default_nettype none

module bmhq_checker
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [HANDLE_W-1:0] top_handle,
    input wire logic [PRIO_W-1:0]   top_priority,
    input wire logic [COUNT_W-1:0]  count
);

    a_out_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result valid dropped under stall");

    a_out_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(top_handle)
            && $stable(top_priority) && $stable(count))
        else $error("result payload changed under stall");

    a_fail_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> top_handle == '0 && top_priority == '0)
        else $error("rejected transfer reports a removed item");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty report with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == COUNT_W'(CAPACITY))
        else $error("full report with count below capacity");

endmodule

bind binary_min_heap_queue_top bmhq_checker #(
    .CAPACITY (CAPACITY)
) u_bmhq_checker (.*);

`default_nettype wire

### tb/binary_min_heap_queue_top_tb.sv
// self-checking testbench for the binary min-heap priority queue top level
`timescale 1ns / 100ps

module binary_min_heap_queue_top_tb;
    import bmhq_pkg::*;

    localparam int QCAP = 16;

    // one result of the queue, as the checker holds it
    typedef struct packed {
        status_t               st;
        logic [HANDLE_W-1:0]   top_h;
        logic [PRIO_W-1:0]     top_p;
        logic [COUNT_W-1:0]    cnt;
    } heap_result_t;

    // one directed operation; lit marks rows whose result is typed in here
    typedef struct packed {
        logic                  cmd;
        logic [HANDLE_W-1:0]   hnd;
        logic [PRIO_W-1:0]     prio;
        logic                  lit;
        logic [STATUS_W-1:0]   st;
        logic [HANDLE_W-1:0]   top_h;
        logic [PRIO_W-1:0]     top_p;
        logic [COUNT_W-1:0]    cnt;
    } stim_row_t;

    localparam stim_row_t DIRECTED [25] = '{
        // empty queue first, then both ends of handle and priority
        '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, ST_EMPTY, 16'h0000, 32'h0000_0000, 5'd0},
        '{CMD_INSERT, 16'hffff, 32'h7fff_ffff, 1'b1, ST_OK,    16'h0000, 32'h0000_0000, 5'd1},
        '{CMD_INSERT, 16'h0000, 32'h8000_0000, 1'b1, ST_OK,    16'h0000, 32'h0000_0000, 5'd2},
        // handle and priority are don't-care on a remove
        '{CMD_REMOVE, 16'h5a5a, 32'h1234_5678, 1'b1, ST_OK,    16'h0000, 32'h8000_0000, 5'd1},
        '{CMD_REMOVE, 16'ha5a5, 32'hedcb_a987, 1'b1, ST_OK,    16'hffff, 32'h7fff_ffff, 5'd0},
        '{CMD_REMOVE, 16'hffff, 32'hffff_ffff, 1'b1, ST_EMPTY, 16'h0000, 32'h0000_0000, 5'd0},
        // fill to capacity, plenty of equal priorities for the tie rules
        '{CMD_INSERT, 16'h0101, 32'd100,       1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0102, 32'd100,       1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0103, 32'd50,        1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0104, 32'd50,        1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0105, -32'sd7,       1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0106, 32'd100,       1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0107, 32'd0,         1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0108, -32'sd7,       1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0109, 32'h7fff_ffff, 1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h010a, 32'h8000_0000, 1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h010b, 32'd3,         1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h010c, 32'd3,         1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h010d, 32'd3,         1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h010e, 32'd42,        1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h010f, -32'sd1,       1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_INSERT, 16'h0110, 32'd50,        1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        // insert into a full queue is refused
        '{CMD_INSERT, 16'hbeef, 32'h0000_0000, 1'b1, ST_FULL,  16'h0000, 32'h0000_0000, 5'd16},
        '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, ST_OK, 16'h0, 32'h0, 5'd0},
        '{CMD_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, ST_OK, 16'h0, 32'h0, 5'd0}
    };

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                command      = CMD_INSERT;
    logic [HANDLE_W-1:0] item_handle  = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic                out_stall    = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] top_handle;
    logic [PRIO_W-1:0]   top_priority;
    logic [COUNT_W-1:0]  count;

    // predicted heap contents, advanced at each input transfer
    logic [HANDLE_W-1:0]        q_handle [QCAP];
    logic signed [PRIO_W-1:0]   q_prio   [QCAP];
    int                         q_fill = 0;

    heap_result_t pending_results [$];
    int           fail_count = 0;

    // idling knobs, percent per cycle
    int sender_idle = 0;
    int stall_pct   = 0;

    // long receiver hold-off: main bumps the token, the receiver counts it down
    int hold_len   = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    binary_min_heap_queue_top #(
        .CAPACITY     (QCAP)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .item_handle  (item_handle),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .top_handle   (top_handle),
        .top_priority (top_priority),
        .count        (count)
    );

    always #6 clk = ~clk;

    // exchange two heap slots of the predicted queue
    function automatic void swap_slots(input int a, input int b);
        logic [HANDLE_W-1:0]      h;
        logic signed [PRIO_W-1:0] p;
        h           = q_handle[a];
        p           = q_prio[a];
        q_handle[a] = q_handle[b];
        q_prio[a]   = q_prio[b];
        q_handle[b] = h;
        q_prio[b]   = p;
    endfunction

    // apply one operation to the predicted heap and return the result it gives
    function automatic heap_result_t apply_op(input logic cmd, input logic [HANDLE_W-1:0] hnd,
                                              input logic [PRIO_W-1:0] prio);
        heap_result_t res;
        int           i;
        int           par;
        int           lc;
        int           rc;
        int           pick;
        int           last;
        res    = '0;
        res.st = ST_OK;
        if (cmd == CMD_INSERT)
        begin
            if (q_fill >= QCAP)
                res.st = ST_FULL;
            else
            begin
                // new leaf, then climb while the parent is strictly larger
                i           = q_fill;
                q_handle[i] = hnd;
                q_prio[i]   = prio;
                q_fill++;
                while (i > 0)
                begin
                    par = (i - 1) / 2;
                    if (q_prio[par] > q_prio[i])
                    begin
                        swap_slots(par, i);
                        i = par;
                    end
                    else
                        break;
                end
            end
        end
        else if (q_fill == 0)
            res.st = ST_EMPTY;
        else
        begin
            last        = q_fill - 1;
            res.top_h   = q_handle[0];
            res.top_p   = q_prio[0];
            q_handle[0] = q_handle[last];
            q_prio[0]   = q_prio[last];
            q_fill      = last;
            // sink the moved leaf; equal children go right, a lone left child stands alone
            i = 0;
            forever
            begin
                lc = 2 * i + 1;
                rc = lc + 1;
                if (lc >= q_fill)
                    break;
                pick = (rc >= q_fill || q_prio[lc] < q_prio[rc]) ? lc : rc;
                if (q_prio[pick] < q_prio[i])
                begin
                    swap_slots(pick, i);
                    i = pick;
                end
                else
                    break;
            end
        end
        res.cnt = COUNT_W'(q_fill);
        return res;
    endfunction

    // priorities lean toward a narrow band so ties are common
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 5))
            0, 1, 2: return PRIO_W'($urandom_range(0, 9)) - PRIO_W'(5);
            3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // offer one operation and record its expected result at the transfer;
    // valid stays high on return so back-to-back transfers need no gap
    task automatic send_op(input logic cmd, input logic [HANDLE_W-1:0] hnd,
                           input logic [PRIO_W-1:0] prio, input logic use_lit,
                           input heap_result_t lit_res);
        heap_result_t predicted;
        while ($urandom_range(0, 99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        item_handle  <= hnd;
        priority_req <= prio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_op(cmd, hnd, prio);
        pending_results.push_back(use_lit ? lit_res : predicted);
    endtask

    // sender goes quiet until every expected result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // random traffic: the fill level chases a wandering target, so the queue
    // sweeps between empty and full; a share of the commands ignore the target
    task automatic run_traffic(input int n_ops, input int idle, input int stall);
        int   target;
        logic cmd;
        sender_idle = idle;
        stall_pct   = stall;
        target      = $urandom_range(0, QCAP + 1);
        for (int k = 0; k < n_ops; k++)
        begin
            if ($urandom_range(0, 24) == 0)
                target = $urandom_range(0, QCAP + 1);
            if ($urandom_range(0, 99) < 15)
                cmd = 1'($urandom_range(0, 1));
            else
                cmd = (q_fill < target) ? CMD_INSERT : CMD_REMOVE;
            send_op(cmd, HANDLE_W'($urandom), pick_prio(), 1'b0, '0);
        end
    endtask

    // result side stall, with an optional long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // every result transfer is checked against the oldest expectation
    always @(posedge clk)
    begin : result_check
        heap_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d handle %h priority %h count %0d",
                       status, top_handle, top_priority, count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (top_handle !== want.top_h)
                begin
                    $error("top_handle mismatch: expected %h, got %h", want.top_h, top_handle);
                    fail_count++;
                end
                if (top_priority !== want.top_p)
                begin
                    $error("top_priority mismatch: expected %h, got %h",
                           want.top_p, top_priority);
                    fail_count++;
                end
                if (count !== want.cnt)
                begin
                    $error("count mismatch: expected %0d, got %0d", want.cnt, count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        heap_result_t lit_res;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back with no idling
        sender_idle = 0;
        stall_pct   = 0;
        foreach (DIRECTED[r])
        begin
            lit_res = '{status_t'(DIRECTED[r].st), DIRECTED[r].top_h,
                        DIRECTED[r].top_p, DIRECTED[r].cnt};
            send_op(DIRECTED[r].cmd, DIRECTED[r].hnd, DIRECTED[r].prio,
                    DIRECTED[r].lit, lit_res);
        end

        // idling phases: none, sender sparse, receiver stalling
        run_traffic(270, 0, 0);
        run_traffic(270, 75, 0);
        run_traffic(270, 0, 75);

        // receiver holds off for a long stretch while the sender keeps offering,
        // so the queue backs up and stalls its input; then drain completely
        hold_len = 300;
        hold_token++;
        run_traffic(40, 0, 0);
        wait_drained();

        // both sides idling lightly
        run_traffic(270, 13, 13);
        wait_drained();

        if (fail_count == 0)
            $display("binary_min_heap_queue_top verification clean");
        else
            $display("binary_min_heap_queue_top verification failed");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("binary_min_heap_queue_top verification failed");
        $finish;
    end

endmodule
